FILE: rtl/core/bfds_pkg.sv
// Shared constants, queue entry type and cell size clamp for the box filter downscaler.
package bfds_pkg;

  localparam int SRC_SIZE = 192;
  localparam int MIN_CELL = 8;
  localparam int SUM_W    = 18;
  localparam int POS_W    = 8;
  localparam int PROD_W   = 16;
  localparam int DIV_W    = SUM_W + 1;
  localparam int CNT_W    = 5;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int NCH      = 4;

  // One finished footprint, handed from the accumulator to the divider.
  typedef struct packed {
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [POS_W-1:0] width;
    logic [POS_W-1:0] height;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] line;
    logic             done;
  } fp_t;

  function automatic logic [POS_W-1:0] eff_cell(input logic [7:0] v);
    logic [POS_W-1:0] c;
    c = v;
    if (v < 8'(MIN_CELL)) c = POS_W'(MIN_CELL);
    if (v > 8'(SRC_SIZE)) c = POS_W'(SRC_SIZE);
    return c;
  endfunction

endpackage

FILE: rtl/core/bfds_front.sv
// Front part: pixel position tracking, footprint edges and per-column channel sums.
module bfds_front import bfds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  input  logic             in_push,
  input  logic [7:0]       in_alpha,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic             q_full,
  output logic             q_push,
  output fp_t              q_data
);

  logic [POS_W-1:0]  c_r, s_r, row_r, oc_r, orow_r, top_r, w_r;
  logic [POS_W-1:0]  c_nxt, s_nxt, row_nxt, oc_nxt, orow_nxt, top_nxt, w_nxt;
  logic [PROD_W-1:0] cp_r, cq_r, rp_r, rq_r;
  logic [PROD_W-1:0] cp_nxt, cq_nxt, rp_nxt, rq_nxt;
  logic [NCH*SUM_W-1:0] mem [SRC_SIZE];
  logic [NCH*SUM_W-1:0] rd_r, acc_r, base, sum;
  logic [POS_W-1:0]  cn;
  logic              accept, close, bottom, first_row;
  logic [NCH-1:0][7:0] pix;

  assign accept    = in_push && !q_full;
  // column footprint ends when (oc+1)*S < (s+2)*C, band ends likewise for rows
  assign close     = cp_r < cq_r;
  assign bottom    = rp_r < rq_r;
  assign first_row = row_r == top_r;
  assign pix       = {in_alpha, in_red, in_green, in_blue};

  always_comb begin
    base = (w_r == '0) ? (first_row ? '0 : rd_r) : acc_r;
    for (int i = 0; i < NCH; i++) begin
      sum[i*SUM_W +: SUM_W] = base[i*SUM_W +: SUM_W] + SUM_W'(pix[i]);
    end
  end

  always_comb begin
    cn       = (cfg_we && rst_n) ? eff_cell(cfg_wdata) : POS_W'(SRC_SIZE);
    c_nxt    = c_r;
    s_nxt    = s_r;
    row_nxt  = row_r;
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    top_nxt  = top_r;
    w_nxt    = w_r;
    cp_nxt   = cp_r;
    cq_nxt   = cq_r;
    rp_nxt   = rp_r;
    rq_nxt   = rq_r;
    if (cfg_we || !rst_n) begin
      c_nxt    = cn;
      s_nxt    = '0;
      row_nxt  = '0;
      oc_nxt   = '0;
      orow_nxt = '0;
      top_nxt  = '0;
      w_nxt    = '0;
      cp_nxt   = PROD_W'(SRC_SIZE);
      cq_nxt   = PROD_W'(cn) << 1;
      rp_nxt   = PROD_W'(SRC_SIZE);
      rq_nxt   = PROD_W'(cn) << 1;
    end else if (accept) begin
      if (close) begin
        oc_nxt = oc_r + 1'b1;
        cp_nxt = cp_r + PROD_W'(SRC_SIZE);
        w_nxt  = '0;
      end else begin
        w_nxt  = w_r + 1'b1;
      end
      s_nxt  = s_r + 1'b1;
      cq_nxt = cq_r + PROD_W'(c_r);
      if (s_r == POS_W'(SRC_SIZE - 1)) begin
        s_nxt  = '0;
        oc_nxt = '0;
        w_nxt  = '0;
        cp_nxt = PROD_W'(SRC_SIZE);
        cq_nxt = PROD_W'(c_r) << 1;
        if (bottom) begin
          orow_nxt = orow_r + 1'b1;
          rp_nxt   = rp_r + PROD_W'(SRC_SIZE);
          top_nxt  = row_r + 1'b1;
        end
        row_nxt = row_r + 1'b1;
        rq_nxt  = rq_r + PROD_W'(c_r);
        if (row_r == POS_W'(SRC_SIZE - 1)) begin
          row_nxt  = '0;
          orow_nxt = '0;
          top_nxt  = '0;
          rp_nxt   = PROD_W'(SRC_SIZE);
          rq_nxt   = PROD_W'(c_r) << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    row_r  <= row_nxt;
    oc_r   <= oc_nxt;
    orow_r <= orow_nxt;
    top_r  <= top_nxt;
    w_r    <= w_nxt;
    cp_r   <= cp_nxt;
    cq_r   <= cq_nxt;
    rp_r   <= rp_nxt;
    rq_r   <= rq_nxt;
  end

  // hold the running sum inside a footprint row, write back when it closes
  always_ff @(posedge clk) begin
    if (accept && !close) begin
      acc_r <= sum;
    end
    if (accept && close) begin
      mem[oc_r] <= sum;
    end
    rd_r <= mem[oc_nxt];
  end

  assign q_push = accept && close && bottom;

  always_comb begin
    q_data.alpha  = sum[3*SUM_W +: SUM_W];
    q_data.red    = sum[2*SUM_W +: SUM_W];
    q_data.green  = sum[1*SUM_W +: SUM_W];
    q_data.blue   = sum[0 +: SUM_W];
    q_data.width  = w_r + 1'b1;
    q_data.height = row_r - top_r + 1'b1;
    q_data.column = oc_r;
    q_data.line   = orow_r;
    q_data.done   = ({1'b0, oc_r} + 9'd1 == {1'b0, c_r}) &&
                    ({1'b0, orow_r} + 9'd1 == {1'b0, c_r});
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("request pushed into full queue");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r < c_r) else $error("output column beyond cell size");
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= row_r) else $error("band top below current row");
`endif

endmodule

FILE: rtl/core/bfds_queue.sv
// Short queue of finished footprints between front and back parts.
module bfds_queue import bfds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  fp_t  wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output fp_t  rdata
);

  fp_t               buf_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/bfds_back.sv
// Back part: footprint area, rounded division of four channel sums, result register.
module bfds_back import bfds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  fp_t              q_data,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_alpha,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_column,
  output logic [7:0]       out_line,
  output logic             out_frame_done
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        st_r, st_nxt;
  fp_t               ent_r;
  logic [PROD_W-1:0] n_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NCH-1:0][DIV_W-1:0]  quo_r;
  logic [NCH-1:0][PROD_W-1:0] rem_r;
  logic [NCH-1:0][SUM_W-1:0]  sums;
  logic [NCH-1:0][PROD_W:0]   trial;
  logic              ov_r, load_out;

  assign sums     = {ent_r.alpha, ent_r.red, ent_r.green, ent_r.blue};
  assign q_pop    = (st_r == ST_IDLE) && !q_empty;
  assign load_out = (st_r == ST_DONE) && (!ov_r || out_pop);
  assign out_empty = !ov_r;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      trial[i] = {rem_r[i], quo_r[i][DIV_W-1]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (!q_empty) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_ADD;
      ST_ADD:  st_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNT_W'(DIV_W - 1)) st_nxt = ST_DONE;
      ST_DONE: if (load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out)     ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (!q_empty) ent_r <= q_data;
      ST_MUL:  n_r <= PROD_W'(ent_r.width) * PROD_W'(ent_r.height);
      ST_ADD: begin
        cnt_r <= '0;
        for (int i = 0; i < NCH; i++) begin
          quo_r[i] <= DIV_W'(sums[i]) + DIV_W'(n_r >> 1);
          rem_r[i] <= '0;
        end
      end
      // restoring division, one quotient bit per cycle on all channels
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < NCH; i++) begin
          if (trial[i] >= {1'b0, n_r}) begin
            rem_r[i] <= PROD_W'(trial[i] - {1'b0, n_r});
            quo_r[i] <= {quo_r[i][DIV_W-2:0], 1'b1};
          end else begin
            rem_r[i] <= PROD_W'(trial[i]);
            quo_r[i] <= {quo_r[i][DIV_W-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_alpha      <= quo_r[3][7:0];
      out_red        <= quo_r[2][7:0];
      out_green      <= quo_r[1][7:0];
      out_blue       <= quo_r[0][7:0];
      out_column     <= ent_r.column;
      out_line       <= ent_r.line;
      out_frame_done <= ent_r.done;
    end
  end

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> n_r != '0) else $error("zero footprint area");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> ov_r) else $error("result not held after load");
`endif

endmodule

FILE: rtl/core/box_filter_image_downscale_core.sv
// Top level of the box filter area-average image downscaler.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_push / in_full | in_alpha, in_red, in_green, in_blue
//  out     | output    | out_pop / out_empty | averages, out_column, out_line, out_frame_done
//  cfg     | input     | cfg_we            | cfg_wdata (cell size)
//
// One pixel is accepted per cycle while the footprint queue has room.
// Each output pixel passes the back part's multiply, add, 19-step restoring divide
// (all four channels at once) and done states before the next footprint is taken.
// Reset is synchronous; sums memory needs no clearing.
// A full queue raises in_full; an untaken result holds the divider.
module box_filter_image_downscale_core import bfds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_alpha,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_alpha,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_column,
  output logic [7:0] out_line,
  output logic       out_frame_done
);

  fp_t  fq_wdata, fq_rdata;
  logic fq_push, fq_full, fq_pop, fq_empty;

  assign in_full = fq_full;

  bfds_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_push,
    .in_alpha, .in_red, .in_green, .in_blue,
    .q_full (fq_full),
    .q_push (fq_push),
    .q_data (fq_wdata)
  );

  bfds_queue u_queue (
    .clk, .rst_n,
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rdata)
  );

  bfds_back u_back (
    .clk, .rst_n,
    .q_empty (fq_empty),
    .q_data  (fq_rdata),
    .q_pop   (fq_pop),
    .out_empty, .out_pop, .out_alpha, .out_red, .out_green, .out_blue,
    .out_column, .out_line, .out_frame_done
  );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the box filter image downscaler core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class downscale_scoreboard;
    typedef struct {
      logic [7:0] alpha, red, green, blue, column, line;
      logic       done;
    } pixel_t;

    pixel_t     awaited[$];
    logic [7:0] cell_reg;
    logic [17:0] acc_a[0:191], acc_r[0:191], acc_g[0:191], acc_b[0:191];
    int unsigned src_col, src_row, cur_col, cur_row, band_top, band_bot;
    int unsigned errors, matched;

    function new();
      cell_reg = 8'd192;
      errors = 0;
      matched = 0;
      restart();
    endfunction

    function int unsigned clamp_cell();
      int unsigned c;
      c = cell_reg;
      if (c < 8) c = 8;
      if (c > 192) c = 192;
      return c;
    endfunction

    function int unsigned boundary(int unsigned i);
      return (i * 192) / clamp_cell();
    endfunction

    function void restart();
      src_col = 0; src_row = 0; cur_col = 0; cur_row = 0; band_top = 0;
      band_bot = boundary(1) - 1;
    endfunction

    function void write_cell(logic [7:0] v);
      cell_reg = v;
      restart();
    endfunction

    function logic [7:0] rounded(logic [17:0] sum, int unsigned n);
      return 8'((int'(sum) + n / 2) / n);
    endfunction

    // Fold one accepted pixel into the column sums; queue a result on a footprint corner.
    function void note_pixel(logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned c, x0, x1, n;
      pixel_t p;
      c = clamp_cell();
      x0 = boundary(cur_col);
      x1 = boundary(cur_col + 1);
      if (src_row == band_top && src_col == x0) begin
        acc_a[cur_col] = a; acc_r[cur_col] = r; acc_g[cur_col] = g; acc_b[cur_col] = b;
      end else begin
        acc_a[cur_col] += a; acc_r[cur_col] += r; acc_g[cur_col] += g; acc_b[cur_col] += b;
      end
      if (src_col + 1 >= x1) begin
        if (src_row == band_bot) begin
          n = (x1 - x0) * (band_bot - band_top + 1);
          p.alpha = rounded(acc_a[cur_col], n);
          p.red = rounded(acc_r[cur_col], n);
          p.green = rounded(acc_g[cur_col], n);
          p.blue = rounded(acc_b[cur_col], n);
          p.column = 8'(cur_col);
          p.line = 8'(cur_row);
          p.done = (cur_col + 1 == c) && (cur_row + 1 == c);
          awaited.push_back(p);
        end
        cur_col++;
      end
      src_col++;
      if (src_col >= 192) begin
        src_col = 0;
        cur_col = 0;
        if (src_row == band_bot) begin
          cur_row++;
          if (cur_row >= c) cur_row = 0;
          band_top = boundary(cur_row);
          band_bot = boundary(cur_row + 1) - 1;
        end
        src_row++;
        if (src_row >= 192) begin
          src_row = 0; cur_row = 0; band_top = 0;
          band_bot = boundary(1) - 1;
        end
      end
    endfunction

    function void field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
    endfunction

    function void check_pixel(logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] col, logic [7:0] ln, logic dn);
      pixel_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected pixel at (%0d,%0d), expected nothing", $realtime,
                   col, ln);
        return;
      end
      want = awaited.pop_front();
      matched++;
      field("alpha", want.alpha, a);
      field("red", want.red, r);
      field("green", want.green, g);
      field("blue", want.blue, b);
      field("column", want.column, col);
      field("line", want.line, ln);
      field("frame_done", 8'(want.done), 8'(dn));
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_alpha = 8'd0, in_red = 8'd0, in_green = 8'd0, in_blue = 8'd0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_alpha, out_red, out_green, out_blue, out_column, out_line;
  logic       out_frame_done;

  downscale_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned hold_off = 0;
  bit          steady = 1'b0;

  box_filter_image_downscale_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_alpha(in_alpha), .in_red(in_red),
    .in_green(in_green), .in_blue(in_blue), .out_empty(out_empty), .out_pop(out_pop),
    .out_alpha(out_alpha), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_column(out_column), .out_line(out_line), .out_frame_done(out_frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Track every accepted request on both channels.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      sb.note_pixel(in_alpha, in_red, in_green, in_blue);
    if (rst_n && out_pop && !out_empty)
      sb.check_pixel(out_alpha, out_red, out_green, out_blue, out_column, out_line,
                     out_frame_done);
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= steady || ($urandom_range(99) >= 18);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] a, r, g, b);
    in_push <= 1'b1;
    in_alpha <= a; in_red <= r; in_green <= g; in_blue <= b;
    do @(posedge clk); while (in_full);
    if (!steady && $urandom_range(99) < 18) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold the input and wait until every queued pixel has come out.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cell(input logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_cell(v);
  endtask

  task automatic run_cell(input logic [7:0] v, input int unsigned n_items,
                          input int unsigned min_pixels);
    int unsigned sent, start;
    write_cell(v);
    sent = 0;
    start = sb.matched;
    while (sent < n_items || sb.matched + sb.awaited.size() - start < min_pixels) begin
      send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      sent++;
    end
  endtask

  initial begin
    int unsigned k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset cell size is a straight pass-through: hit field extremes and bit patterns.
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'h01, 8'h80, 8'h7F, 8'hFE);
    for (k = 0; k < 14; k++) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());

    // Let the receiver stall long enough for the input side to back up.
    write_cell(8'd192);
    hold_off = 300;
    for (k = 0; k < 200; k++) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());

    // Above range clamps to the source size.
    run_cell(8'd255, 100, 0);

    // Uneven footprints; pause mid-stream until the output side is empty.
    write_cell(8'd191);
    for (k = 0; k < 160; k++) begin
      if (k == 80) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end

    // Zero clamps to the minimum cell.
    run_cell(8'd0, 80, 0);

    steady = 1'b1;
    run_cell(8'd100, 150, 40);
    steady = 1'b0;

    run_cell(8'd7, 40, 0);
    run_cell(8'd9, 40, 0);
    run_cell(8'd8, 40, 0);
    run_cell(8'd64, 200, 20);

    drain();
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/bfds_pkg.sv
rtl/core/bfds_front.sv
rtl/core/bfds_queue.sv
rtl/core/bfds_back.sv
rtl/core/box_filter_image_downscale_core.sv
test/tb_top.sv
